>>> hw/rtl/thadc_pkg.sv
// ----------------------------------------------------------------------------
// thadc_pkg
// Shared widths, constants and types for the thermistor linearisation pipe.
// ----------------------------------------------------------------------------
package thadc_pkg;

  localparam int NUM_W    = 30;  // divider numerator, up to 999 * (2^20 - 1)
  localparam int DEN_W    = 10;
  localparam int MANT_W   = 31;  // log2 mantissa, Q30 in [1, 2)
  localparam int LOG_FRAC = 28;  // fraction bits of log2 result
  localparam int LOG_W    = 33;  // 5 integer + 28 fraction bits
  localparam int LNR_W    = 30;  // signed Q24 ln R
  localparam int LN2_W    = 35;
  localparam int LN3_W    = 40;
  localparam int BT_W     = 54;
  localparam int D_W      = 64;  // signed Q40 denominator
  localparam int MAG_W    = 63;
  localparam int QBITS    = 33;  // quotient bits kept by the divider
  localparam int COEFF_W  = 48;
  localparam int OHMS_W   = 20;
  localparam int RSHIFT   = 24;  // Q24 rescale after products
  localparam int SPLIT    = 24;  // low slice of a split multiplier operand

  localparam logic [29:0] LN2_Q30      = 30'd744261118;
  localparam logic [31:0] FALLBACK_Q16 = 32'h0019_0000;

  typedef enum logic [1:0] {
    REG_COEFF_A = 2'd0,
    REG_COEFF_B = 2'd1,
    REG_COEFF_C = 2'd2,
    REG_REF_OHMS = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic fb;   // result replaced by the fallback value
    logic neg;  // denominator negative
  } side_t;

endpackage

>>> hw/rtl/thadc_log2.sv
// ----------------------------------------------------------------------------
// thadc_log2
// Pipelined log2 of a positive integer: normalise, then one squaring step
// per fraction bit. Unsigned Q28 result.
// ----------------------------------------------------------------------------
module thadc_log2 import thadc_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] x,
  output logic [LOG_W-1:0] lg
);

  logic [4:0]        e;
  logic [MANT_W-1:0] mn;
  logic [MANT_W-1:0] m [0:LOG_FRAC];
  logic [LOG_W-1:0]  r [0:LOG_FRAC];

  // top set bit and normalised mantissa
  always_comb begin
    e = '0;
    for (int i = 0; i < NUM_W; i++) begin
      if (x[i]) e = 5'(i);
    end
    mn = MANT_W'({1'b0, x} << (5'd30 - e));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= mn;
      r[0] <= {e, {LOG_FRAC{1'b0}}};
    end
  end

  for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_step
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     t;
    always_comb begin
      sq = m[k-1] * m[k-1];
      t  = sq[2*MANT_W-1:MANT_W-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (t[MANT_W]) begin
          m[k] <= t[MANT_W:1];
          r[k] <= r[k-1] | (LOG_W'(1) << (LOG_FRAC - k));
        end else begin
          m[k] <= t[MANT_W-1:0];
          r[k] <= r[k-1];
        end
      end
    end
  end

  assign lg = r[LOG_FRAC];

endmodule

>>> hw/rtl/thadc_mulr.sv
// ----------------------------------------------------------------------------
// thadc_mulr
// Signed multiply with rounding shift by 2^24, halves away from zero.
// Operand a is split into two slices.
// ----------------------------------------------------------------------------
module thadc_mulr import thadc_pkg::*; #(
  parameter int AW = 30,
  parameter int BW = 30,
  parameter int RW = 35
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [RW-1:0] res
);

  localparam int PW = AW + BW;

  logic [AW-1:0]         ma;
  logic [BW-1:0]         mb;
  logic                  neg1, neg2;
  logic [SPLIT+BW-1:0]   pl;
  logic [AW-SPLIT+BW-1:0] ph;
  logic [PW:0]           sum;
  logic [RW-1:0]         mag;

  always_ff @(posedge clk) begin
    if (en) begin
      ma   <= a[AW-1] ? AW'(-a) : AW'(a);
      mb   <= b[BW-1] ? BW'(-b) : BW'(b);
      neg1 <= a[AW-1] ^ b[BW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl   <= ma[SPLIT-1:0] * mb;
      ph   <= ma[AW-1:SPLIT] * mb;
      neg2 <= neg1;
    end
  end

  always_comb begin
    sum = (PW+1)'(pl) + ((PW+1)'(ph) << SPLIT) + ((PW+1)'(1) << (RSHIFT - 1));
    mag = sum[RW+RSHIFT-1:RSHIFT];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= neg2 ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

>>> hw/rtl/thadc_div.sv
// ----------------------------------------------------------------------------
// thadc_div
// Pipelined restoring divider, one quotient bit per stage, 33 stages.
// The caller guarantees the quotient stays below 2^33.
// ----------------------------------------------------------------------------
module thadc_div import thadc_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [MAG_W-1:0] dvd,
  input  logic [MAG_W-1:0] dvs,
  output logic [QBITS-1:0] q
);

  logic [MAG_W-1:0] rem [0:QBITS];
  logic [MAG_W-1:0] ds  [0:QBITS];
  logic [QBITS-1:0] qs  [0:QBITS];

  assign rem[0] = dvd;
  assign ds[0]  = dvs;
  assign qs[0]  = '0;

  for (genvar j = 1; j <= QBITS; j++) begin : g_bit
    localparam int K = QBITS - j;
    logic [MAG_W+QBITS-1:0] sh;
    logic                   take;
    always_comb begin
      sh   = (MAG_W+QBITS)'(ds[j-1]) << K;
      take = (MAG_W+QBITS)'(rem[j-1]) >= sh;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= take ? rem[j-1] - sh[MAG_W-1:0] : rem[j-1];
        ds[j]  <= ds[j-1];
        qs[j]  <= take ? qs[j-1] | (QBITS'(1) << K) : qs[j-1];
      end
    end
  end

  assign q = qs[QBITS];

endmodule

>>> hw/rtl/thermistor_adc_to_temperature.sv
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature
// Steinhart-Hart linearisation of thermistor ADC samples, Q16.16 kelvin.
// ----------------------------------------------------------------------------
// One sample is accepted every cycle unless the pipe stalls; its path runs
// through the two 28-step log2 pipes and the 33-stage divider. The whole
// pipe stalls only while a finished result waits at the output and the sink
// is not ready. Coefficients must be written only while the pipe is empty;
// the block itself does not enforce this. A zero denominator, a quotient
// beyond the signed 32-bit range or a zero reference gives 25.0, tuser set.
module thermistor_adc_to_temperature import thadc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] adc_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] temperature
  output logic [0:0]  m_tuser,   // [0] fallback_used
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int DEPTH  = 78;
  localparam int P_PREP = 43;
  localparam int P_DIV  = 76;

  logic signed [COEFF_W-1:0] coeff_a, coeff_b, coeff_c;
  logic [OHMS_W-1:0]         ref_ohms;

  logic              en;
  logic              vld [0:DEPTH-1];
  side_t             side [0:P_DIV];

  logic [7:0]        idx;
  logic [DEN_W-1:0]  mult, den_c;
  logic [NUM_W-1:0]  num_c;
  logic [NUM_W-1:0]  num_r;
  logic [NUM_W-1:0]  den_r;
  logic [LOG_W-1:0]  lg_num, lg_den;
  logic signed [LOG_W:0] ldiff;
  logic [LOG_W-1:0]  mag_l;
  logic              neg_l, neg_p;
  logic [62:0]       prod;
  logic [63:0]       psum;
  logic signed [LNR_W-1:0] lnr;
  logic signed [LNR_W-1:0] lnr_d [0:5];
  logic signed [LN2_W-1:0] ln2;
  logic signed [LN3_W-1:0] ln3;
  logic signed [BT_W-1:0]  bt;
  logic signed [D_W-1:0]   ct;
  logic signed [D_W-1:0]   d_r;
  logic [D_W-1:0]    md_w;
  logic [MAG_W-1:0]  md, dvd;
  logic [MAG_W-1:0]  md_r, dvd_r;
  logic              dz, ovf0;
  logic [QBITS-1:0]  q;
  logic              bad;
  logic [31:0]       temp_r;
  logic              fb_r;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_a  <= '0;
      coeff_b  <= '0;
      coeff_c  <= '0;
      ref_ohms <= OHMS_W'(10000);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEFF_A:  coeff_a  <= cfg_data;
        REG_COEFF_B:  coeff_b  <= cfg_data;
        REG_COEFF_C:  coeff_c  <= cfg_data;
        REG_REF_OHMS: ref_ohms <= cfg_data[OHMS_W-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !vld[DEPTH-1] || m_tready;
  assign s_tready = en;

  // valid and side flags travel with the item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int k = 1; k < DEPTH; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{fb: (num_c == '0), neg: 1'b0};
      for (int k = 1; k <= P_DIV; k++) begin
        if (k == P_PREP) begin
          side[k] <= '{fb: side[k-1].fb | dz | ovf0, neg: md_w != '0 && d_r[D_W-1]};
        end else begin
          side[k] <= side[k-1];
        end
      end
    end
  end

  // divider ratio as an exact fraction
  always_comb begin
    idx = s_tdata[11:4];
    case (idx)
      8'd0: begin
        mult  = DEN_W'(1);
        den_c = DEN_W'(999);
      end
      8'd255: begin
        mult  = DEN_W'(999);
        den_c = DEN_W'(1);
      end
      default: begin
        mult  = DEN_W'(idx);
        den_c = DEN_W'(8'd255 - idx);
      end
    endcase
    num_c = NUM_W'(ref_ohms) * NUM_W'(mult);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_c;
      den_r <= NUM_W'(den_c);
    end
  end

  thadc_log2 u_log_num (.clk(clk), .en(en), .x(num_r), .lg(lg_num));
  thadc_log2 u_log_den (.clk(clk), .en(en), .x(den_r), .lg(lg_den));

  // ln R = log2 ratio * ln 2
  assign ldiff = $signed({1'b0, lg_num}) - $signed({1'b0, lg_den});

  always_ff @(posedge clk) begin
    if (en) begin
      mag_l <= ldiff[LOG_W] ? LOG_W'(-ldiff) : LOG_W'(ldiff);
      neg_l <= ldiff[LOG_W];
      prod  <= 63'(mag_l) * 63'(LN2_Q30);
      neg_p <= neg_l;
    end
  end

  assign psum = 64'(prod) + (64'(1) << 33);

  always_ff @(posedge clk) begin
    if (en) begin
      lnr <= neg_p ? -$signed(LNR_W'(psum[62:34])) : $signed(LNR_W'(psum[62:34]));
      lnr_d[0] <= lnr;
      for (int k = 1; k < 6; k++) lnr_d[k] <= lnr_d[k-1];
    end
  end

  thadc_mulr #(.AW(LNR_W), .BW(LNR_W), .RW(LN2_W)) u_sq (
    .clk(clk), .en(en), .a(lnr), .b(lnr), .res(ln2));
  thadc_mulr #(.AW(LN2_W), .BW(LNR_W), .RW(LN3_W)) u_cube (
    .clk(clk), .en(en), .a(ln2), .b(lnr_d[2]), .res(ln3));
  thadc_mulr #(.AW(COEFF_W), .BW(LNR_W), .RW(BT_W)) u_bterm (
    .clk(clk), .en(en), .a(coeff_b), .b(lnr_d[5]), .res(bt));
  thadc_mulr #(.AW(COEFF_W), .BW(LN3_W), .RW(D_W)) u_cterm (
    .clk(clk), .en(en), .a(coeff_c), .b(ln3), .res(ct));

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= D_W'(coeff_a) + D_W'(bt) + ct;
    end
  end

  // reciprocal set-up: rounded 2^56 / |D|, overflow screened up front
  always_comb begin
    md_w = d_r[D_W-1] ? D_W'(-d_r) : D_W'(d_r);
    md   = md_w[MAG_W-1:0];
    dz   = (d_r == '0);
    dvd  = (MAG_W'(1) << 56) + (md >> 1);
    ovf0 = MAG_W'(dvd[MAG_W-1:QBITS]) >= md;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_r <= dvd;
      md_r  <= md;
    end
  end

  thadc_div u_div (.clk(clk), .en(en), .dvd(dvd_r), .dvs(md_r), .q(q));

  assign bad = side[P_DIV].fb ||
               (!side[P_DIV].neg && q > QBITS'(32'h7FFF_FFFF)) ||
               (side[P_DIV].neg && q > QBITS'(32'h8000_0000));

  always_ff @(posedge clk) begin
    if (en) begin
      fb_r   <= bad;
      temp_r <= bad ? FALLBACK_Q16 :
                side[P_DIV].neg ? -q[31:0] : q[31:0];
    end
  end

  assign m_tvalid   = vld[DEPTH-1];
  assign m_tdata    = temp_r;
  assign m_tuser[0] = fb_r;

  a_fallback_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == FALLBACK_Q16)
    else $error("fallback flag without fallback value");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted item not captured");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(vld[DEPTH-2]) && $stable(temp_r))
    else $error("pipe moved while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

endmodule
